@@ hdl/hkrb_pkg.sv @@
// Shared types and constants for the HID keyboard report builder.
package hkrb_pkg;

  // Slot store sizing
  localparam int KEY_SLOTS_DEF = 6;
  localparam int KEY_SLOTS_MAX = 16;
  localparam int REPORT_SLOTS  = 6;

  // Result status codes
  localparam logic [1:0] ST_UPDATED = 2'd0;
  localparam logic [1:0] ST_REPEAT  = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Base HID usages of the contiguous key groups
  localparam logic [7:0] USAGE_A  = 8'h04;
  localparam logic [7:0] USAGE_1  = 8'h1E;
  localparam logic [7:0] USAGE_0  = 8'h27;
  localparam logic [7:0] USAGE_F1 = 8'h3A;

  // Translated key: either a modifier mask or a usage
  typedef struct packed {
    logic       ok;
    logic       is_mod;
    logic [7:0] mod_mask;
    logic [7:0] usage;
  } key_xlat_t;

  // One result: status and the report as it stands after the request
  typedef struct packed {
    logic [1:0]                   status;
    logic [7:0]                   modifier_bits;
    logic [REPORT_SLOTS-1:0][7:0] slots;
  } report_t;

endpackage

@@ hdl/hkrb_if.sv @@
// Valid/ready channel interfaces for key events and reports.
interface hkrb_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] virtual_key;

  modport source(output valid, mode, virtual_key, input ready);
  modport sink(input valid, mode, virtual_key, output ready);
endinterface

interface hkrb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] modifier_bits;
  logic [7:0] slot_zero;
  logic [7:0] slot_one;
  logic [7:0] slot_two;
  logic [7:0] slot_three;
  logic [7:0] slot_four;
  logic [7:0] slot_five;

  modport source(output valid, status, modifier_bits, slot_zero, slot_one, slot_two,
                 slot_three, slot_four, slot_five, input ready);
  modport sink(input valid, status, modifier_bits, slot_zero, slot_one, slot_two,
               slot_three, slot_four, slot_five, output ready);
endinterface

@@ hdl/hkrb_xlat.sv @@
// Virtual key code to HID modifier bit or usage translation.
module hkrb_xlat (
  input  logic              [7:0] vk,
  output hkrb_pkg::key_xlat_t     xlat
);
  import hkrb_pkg::*;

  localparam logic [7:0] VK_A  = 8'h41;
  localparam logic [7:0] VK_1  = 8'h31;
  localparam logic [7:0] VK_F1 = 8'h70;

  // decoder over the fixed key table
  always_comb begin
    xlat    = '0;
    xlat.ok = 1'b1;
    unique case (vk) inside
      // modifiers, LCtrl..RGui in bits 0..7
      8'hA2: begin xlat.is_mod = 1'b1; xlat.mod_mask = 8'h01; end
      8'hA0: begin xlat.is_mod = 1'b1; xlat.mod_mask = 8'h02; end
      8'hA4: begin xlat.is_mod = 1'b1; xlat.mod_mask = 8'h04; end
      8'h5B: begin xlat.is_mod = 1'b1; xlat.mod_mask = 8'h08; end
      8'hA3: begin xlat.is_mod = 1'b1; xlat.mod_mask = 8'h10; end
      8'hA1: begin xlat.is_mod = 1'b1; xlat.mod_mask = 8'h20; end
      8'hA5: begin xlat.is_mod = 1'b1; xlat.mod_mask = 8'h40; end
      8'h5C: begin xlat.is_mod = 1'b1; xlat.mod_mask = 8'h80; end
      // letters, digits, function keys
      [8'h41:8'h5A]: xlat.usage = 8'(USAGE_A + (vk - VK_A));
      [8'h31:8'h39]: xlat.usage = 8'(USAGE_1 + (vk - VK_1));
      8'h30:         xlat.usage = USAGE_0;
      [8'h70:8'h7B]: xlat.usage = 8'(USAGE_F1 + (vk - VK_F1));
      // remaining keys, one by one
      8'h0D: xlat.usage = 8'h28;
      8'h1B: xlat.usage = 8'h29;
      8'h08: xlat.usage = 8'h2A;
      8'h09: xlat.usage = 8'h2B;
      8'h20: xlat.usage = 8'h2C;
      8'hBD: xlat.usage = 8'h2D;
      8'hBB: xlat.usage = 8'h2E;
      8'hDB: xlat.usage = 8'h2F;
      8'hDD: xlat.usage = 8'h30;
      8'hDC: xlat.usage = 8'h31;
      8'hBA: xlat.usage = 8'h33;
      8'hDE: xlat.usage = 8'h34;
      8'hC0: xlat.usage = 8'h35;
      8'hBC: xlat.usage = 8'h36;
      8'hBE: xlat.usage = 8'h37;
      8'hBF: xlat.usage = 8'h38;
      8'h14: xlat.usage = 8'h39;
      8'h2C: xlat.usage = 8'h46;
      8'h91: xlat.usage = 8'h47;
      8'h13: xlat.usage = 8'h48;
      8'h2D: xlat.usage = 8'h49;
      8'h24: xlat.usage = 8'h4A;
      8'h21: xlat.usage = 8'h4B;
      8'h2E: xlat.usage = 8'h4C;
      8'h23: xlat.usage = 8'h4D;
      8'h22: xlat.usage = 8'h4E;
      8'h27: xlat.usage = 8'h4F;
      8'h25: xlat.usage = 8'h50;
      8'h28: xlat.usage = 8'h51;
      8'h26: xlat.usage = 8'h52;
      8'h90: xlat.usage = 8'h53;
      8'h6F: xlat.usage = 8'h54;
      8'h6A: xlat.usage = 8'h55;
      8'h6D: xlat.usage = 8'h56;
      8'h6B: xlat.usage = 8'h57;
      8'h6E: xlat.usage = 8'h63;
      default: xlat.ok = 1'b0;
    endcase
  end

endmodule

@@ hdl/hkrb_keystate.sv @@
// Held modifier byte and usage slots, with the per-request update.
module hkrb_keystate #(
  parameter int KEY_SLOTS = hkrb_pkg::KEY_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                press,
  input  hkrb_pkg::key_xlat_t xlat,
  output hkrb_pkg::report_t   report
);
  import hkrb_pkg::*;

  logic [7:0]                   mods_r, mods_nxt;
  logic [KEY_SLOTS-1:0][7:0]    slots_r, slots_nxt;
  logic [KEY_SLOTS-1:0]         match, empty, match_first, empty_first;
  logic [1:0]                   status;
  logic [REPORT_SLOTS-1:0][7:0] shown;

  // per-slot compares
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      match[i] = (slots_r[i] == xlat.usage);
      empty[i] = (slots_r[i] == 8'h00);
    end
  end

  // lowest set bit picks the slot
  assign match_first = match & (~match + KEY_SLOTS'(1));
  assign empty_first = empty & (~empty + KEY_SLOTS'(1));

  // next state and status
  always_comb begin
    mods_nxt  = mods_r;
    slots_nxt = slots_r;
    status    = ST_UPDATED;
    if (!xlat.ok) begin
      status = ST_UNKNOWN;
    end else if (press) begin
      if (xlat.is_mod) begin
        if ((mods_r & xlat.mod_mask) != 8'h00) status = ST_REPEAT;
        else mods_nxt = mods_r | xlat.mod_mask;
      end else if (|match) begin
        status = ST_REPEAT;
      end else if (|empty) begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (empty_first[i]) slots_nxt[i] = xlat.usage;
        end
      end else begin
        status = ST_FULL;
      end
    end else begin
      if (xlat.is_mod) begin
        mods_nxt = mods_r & ~xlat.mod_mask;
      end else begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (match_first[i]) slots_nxt[i] = 8'h00;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r  <= '0;
      slots_r <= '0;
    end else if (fire) begin
      mods_r  <= mods_nxt;
      slots_r <= slots_nxt;
    end
  end

  // report view: slots past KEY_SLOTS read empty
  for (genvar r = 0; r < REPORT_SLOTS; r++) begin : g_shown
    if (r < KEY_SLOTS) begin : g_live
      assign shown[r] = slots_nxt[r];
    end else begin : g_none
      assign shown[r] = 8'h00;
    end
  end

  always_comb begin
    report.status        = status;
    report.modifier_bits = mods_nxt;
    report.slots         = shown;
  end

  // full is only reported with no empty slot
  a_full_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fire && status == ST_FULL |-> empty == '0)
    else $error("full status with an empty slot");

  // untranslatable key leaves the state alone
  a_unknown_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !xlat.ok |=> $stable(mods_r) && $stable(slots_r))
    else $error("untranslatable key changed state");

  // modifier release clears its bit
  a_mod_release: assert property (@(posedge clk) disable iff (!rst_n)
    fire && xlat.ok && xlat.is_mod && !press |=> (mods_r & $past(xlat.mod_mask)) == 8'h00)
    else $error("modifier bit still set after release");

  // state only moves on a processed request
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(mods_r) && $stable(slots_r))
    else $error("state changed without a request");

endmodule

@@ hdl/hid_keyboard_report_builder.sv @@
// Top level: input register, translation and slot update, result register.
//
//   channel   | dir | handshake    | payload
//   in_chan   | in  | valid/ready  | mode, virtual_key
//   out_chan  | out | valid/ready  | status, modifier_bits, slot_zero..slot_five
//
// One request per cycle while the result is taken; a request passes the input register
// and then the result register before its report is valid.
// The rate is set by the single update pass over the slots between the
// input register and the result register.
// Synchronous active-low reset empties both registers and clears all slots.
// A stalled result holds the stage; the input register takes one more request,
// then in_chan.ready stays low until the result is taken.
module hid_keyboard_report_builder #(
  parameter int KEY_SLOTS = hkrb_pkg::KEY_SLOTS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  hkrb_in_if.sink   in_chan,
  hkrb_out_if.source out_chan
);
  import hkrb_pkg::*;

  logic       in_vld_r;
  logic       in_mode_r;
  logic [7:0] in_vk_r;
  logic       out_vld_r;
  report_t    out_rpt_r;
  logic       fire;
  key_xlat_t  xlat;
  report_t    rpt;

  // stage handshake
  assign fire          = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_mode_r <= in_chan.mode;
      in_vk_r   <= in_chan.virtual_key;
    end
  end

  hkrb_xlat u_xlat (
    .vk   (in_vk_r),
    .xlat (xlat)
  );

  hkrb_keystate #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_keystate (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .press  (in_mode_r),
    .xlat   (xlat),
    .report (rpt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rpt_r <= rpt;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.status        = out_rpt_r.status;
  assign out_chan.modifier_bits = out_rpt_r.modifier_bits;
  assign out_chan.slot_zero     = out_rpt_r.slots[0];
  assign out_chan.slot_one      = out_rpt_r.slots[1];
  assign out_chan.slot_two      = out_rpt_r.slots[2];
  assign out_chan.slot_three    = out_rpt_r.slots[3];
  assign out_chan.slot_four     = out_rpt_r.slots[4];
  assign out_chan.slot_five     = out_rpt_r.slots[5];

endmodule

@@ sim/hid_keyboard_report_builder_tb.sv @@
// Testbench for the HID keyboard report builder: directed and random key requests checked
// against a cycle-free model of the modifier byte and the six usage slots.
module hid_keyboard_report_builder_tb;
  import hkrb_pkg::*;

  localparam int KEY_SLOTS    = KEY_SLOTS_DEF;
  localparam int TOTAL_EVENTS = 1650;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 600000;

  logic clk = 1'b0;
  logic rst_n;

  hkrb_in_if  key_if();
  hkrb_out_if rpt_if();

  hid_keyboard_report_builder #(.KEY_SLOTS(KEY_SLOTS)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (key_if),
    .out_chan(rpt_if)
  );

  always #5 clk = ~clk;

  // Model state: keys held as the block should see them
  logic [7:0] held_mask;
  logic [7:0] held_usage [KEY_SLOTS];
  report_t    pending_reports [$];
  logic [7:0] typable_keys [$];
  int         fail_count;
  int         events_sent;
  bit         gapless;
  int         cycle_count;
  int         ready_run;
  int         stall_run;

  // Virtual key to modifier bit or HID usage
  function automatic key_xlat_t decode_key(logic [7:0] vk);
    key_xlat_t x;
    x = '0;
    x.ok = 1'b1;
    case (vk)
      8'hA2: begin x.is_mod = 1'b1; x.mod_mask = 8'h01; end
      8'hA0: begin x.is_mod = 1'b1; x.mod_mask = 8'h02; end
      8'hA4: begin x.is_mod = 1'b1; x.mod_mask = 8'h04; end
      8'h5B: begin x.is_mod = 1'b1; x.mod_mask = 8'h08; end
      8'hA3: begin x.is_mod = 1'b1; x.mod_mask = 8'h10; end
      8'hA1: begin x.is_mod = 1'b1; x.mod_mask = 8'h20; end
      8'hA5: begin x.is_mod = 1'b1; x.mod_mask = 8'h40; end
      8'h5C: begin x.is_mod = 1'b1; x.mod_mask = 8'h80; end
      8'h0D: x.usage = 8'h28;
      8'h1B: x.usage = 8'h29;
      8'h08: x.usage = 8'h2A;
      8'h09: x.usage = 8'h2B;
      8'h20: x.usage = 8'h2C;
      8'hBD: x.usage = 8'h2D;
      8'hBB: x.usage = 8'h2E;
      8'hDB: x.usage = 8'h2F;
      8'hDD: x.usage = 8'h30;
      8'hDC: x.usage = 8'h31;
      8'hBA: x.usage = 8'h33;
      8'hDE: x.usage = 8'h34;
      8'hC0: x.usage = 8'h35;
      8'hBC: x.usage = 8'h36;
      8'hBE: x.usage = 8'h37;
      8'hBF: x.usage = 8'h38;
      8'h14: x.usage = 8'h39;
      8'h2C: x.usage = 8'h46;
      8'h91: x.usage = 8'h47;
      8'h13: x.usage = 8'h48;
      8'h2D: x.usage = 8'h49;
      8'h24: x.usage = 8'h4A;
      8'h21: x.usage = 8'h4B;
      8'h2E: x.usage = 8'h4C;
      8'h23: x.usage = 8'h4D;
      8'h22: x.usage = 8'h4E;
      8'h27: x.usage = 8'h4F;
      8'h25: x.usage = 8'h50;
      8'h28: x.usage = 8'h51;
      8'h26: x.usage = 8'h52;
      8'h90: x.usage = 8'h53;
      8'h6F: x.usage = 8'h54;
      8'h6A: x.usage = 8'h55;
      8'h6D: x.usage = 8'h56;
      8'h6B: x.usage = 8'h57;
      8'h6E: x.usage = 8'h63;
      default: begin
        // contiguous groups: letters, digits, function keys
        if (vk >= 8'h41 && vk <= 8'h5A)      x.usage = USAGE_A + (vk - 8'h41);
        else if (vk >= 8'h31 && vk <= 8'h39) x.usage = USAGE_1 + (vk - 8'h31);
        else if (vk == 8'h30)                x.usage = USAGE_0;
        else if (vk >= 8'h70 && vk <= 8'h7B) x.usage = USAGE_F1 + (vk - 8'h70);
        else                                 x.ok = 1'b0;
      end
    endcase
    return x;
  endfunction

  // Apply one key request to the model and return the report it should produce
  function automatic report_t apply_key_event(logic press, logic [7:0] vk);
    key_xlat_t x;
    report_t   r;
    int        free_idx;
    bit        seen;
    bit        cleared;
    x        = decode_key(vk);
    r        = '0;
    r.status = ST_UPDATED;
    free_idx = -1;
    seen     = 1'b0;
    cleared  = 1'b0;
    if (!x.ok) begin
      r.status = ST_UNKNOWN;
    end else if (x.is_mod) begin
      if (press && (held_mask & x.mod_mask) != 0) r.status = ST_REPEAT;
      else if (press) held_mask = held_mask | x.mod_mask;
      else held_mask = held_mask & ~x.mod_mask;
    end else if (press) begin
      // scan downward so free_idx ends on the lowest empty slot
      for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
        if (held_usage[i] == x.usage) seen = 1'b1;
        if (held_usage[i] == 8'h00) free_idx = i;
      end
      if (seen) r.status = ST_REPEAT;
      else if (free_idx < 0) r.status = ST_FULL;
      else held_usage[free_idx] = x.usage;
    end else begin
      // release empties the lowest slot holding the usage, if any
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (!cleared && held_usage[i] == x.usage) begin
          held_usage[i] = 8'h00;
          cleared = 1'b1;
        end
      end
    end
    r.modifier_bits = held_mask;
    for (int i = 0; i < KEY_SLOTS && i < REPORT_SLOTS; i++) r.slots[i] = held_usage[i];
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%02h, actual 0x%02h", name, want, got);
      fail_count++;
    end
  endfunction

  // Mostly short idle gaps, a few long ones
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Predict on each accepted request, compare each accepted report
  always @(posedge clk) begin : report_monitor
    report_t want;
    if (rst_n) begin
      if (key_if.valid && key_if.ready)
        pending_reports.push_back(apply_key_event(key_if.mode, key_if.virtual_key));
      if (rpt_if.valid && rpt_if.ready) begin
        if (pending_reports.size() == 0) begin
          $error("report with no pending request: status %0d", rpt_if.status);
          fail_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("status", 8'(want.status), 8'(rpt_if.status));
          check_field("modifier_bits", want.modifier_bits, rpt_if.modifier_bits);
          check_field("slot_zero", want.slots[0], rpt_if.slot_zero);
          check_field("slot_one", want.slots[1], rpt_if.slot_one);
          check_field("slot_two", want.slots[2], rpt_if.slot_two);
          check_field("slot_three", want.slots[3], rpt_if.slot_three);
          check_field("slot_four", want.slots[4], rpt_if.slot_four);
          check_field("slot_five", want.slots[5], rpt_if.slot_five);
        end
      end
    end
  end

  // Result-side backpressure: free-running stretches, single cycles and stalls
  always @(posedge clk) begin : report_backpressure
    int roll;
    if (ready_run > 0) begin
      ready_run--;
      rpt_if.ready <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
      rpt_if.ready <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        ready_run = $urandom_range(20, 80);
        rpt_if.ready <= 1'b1;
      end else if (roll < 55) begin
        rpt_if.ready <= 1'b1;
      end else begin
        stall_run = idle_length() - 1;
        rpt_if.ready <= 1'b0;
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout with %0d reports pending", pending_reports.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Send one key request; valid stays high across back-to-back requests
  task automatic send_key_event(logic press, logic [7:0] vk);
    int gap;
    gap = 0;
    if (!gapless && $urandom_range(0, 1) == 1) gap = idle_length();
    if (gap > 0) begin
      key_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_if.valid       <= 1'b1;
    key_if.mode        <= press;
    key_if.virtual_key <= vk;
    @(posedge clk);
    while (!key_if.ready) @(posedge clk);
    events_sent++;
  endtask

  // Hold off the sender until every pending report has come back
  task automatic wait_for_reports();
    key_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // Every modifier, a repeated press, release and release of one not held
  task automatic test_modifier_keys();
    logic [7:0] mods [8];
    mods = '{8'hA2, 8'hA0, 8'hA4, 8'h5B, 8'hA3, 8'hA1, 8'hA5, 8'h5C};
    foreach (mods[i]) send_key_event(1'b1, mods[i]);
    send_key_event(1'b1, 8'hA2);
    send_key_event(1'b0, 8'hA2);
    send_key_event(1'b0, 8'hA2);
  endtask

  // Group edges fill all slots, then a seventh key, a repeat and slot reuse
  task automatic test_usage_slots();
    send_key_event(1'b1, 8'h41);
    send_key_event(1'b1, 8'h5A);
    send_key_event(1'b1, 8'h31);
    send_key_event(1'b1, 8'h39);
    send_key_event(1'b1, 8'h30);
    send_key_event(1'b1, 8'h70);
    send_key_event(1'b1, 8'h7B);
    send_key_event(1'b1, 8'h41);
    send_key_event(1'b0, 8'h5A);
    send_key_event(1'b1, 8'h6E);
    send_key_event(1'b0, 8'h7B);
  endtask

  // Codes with no translation, on press and on release
  task automatic test_unknown_keys();
    send_key_event(1'b1, 8'hFF);
    send_key_event(1'b0, 8'h00);
  endtask

  // Typing over a changing set of keys, with some noise and one full drain
  task automatic test_random_typing();
    logic [7:0] working [$];
    int         roll;
    bit         drained;
    drained = 1'b0;
    while (events_sent < TOTAL_EVENTS) begin
      if (working.size() == 0 || $urandom_range(0, 79) == 0) begin
        // let go of most keys of the old set before switching
        foreach (working[i]) if ($urandom_range(0, 3) != 0) send_key_event(1'b0, working[i]);
        working.delete();
        repeat ($urandom_range(4, 12))
          working.push_back(typable_keys[$urandom_range(0, typable_keys.size() - 1)]);
        gapless = ($urandom_range(0, 4) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) send_key_event(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      else send_key_event(roll < 58, working[$urandom_range(0, working.size() - 1)]);
      if (!drained && events_sent >= TOTAL_EVENTS / 2) begin
        wait_for_reports();
        drained = 1'b1;
      end
    end
    gapless = 1'b0;
  endtask

  initial begin
    key_xlat_t x;
    rst_n              = 1'b0;
    key_if.valid       = 1'b0;
    key_if.mode        = 1'b0;
    key_if.virtual_key = 8'h00;
    rpt_if.ready       = 1'b0;
    held_mask          = 8'h00;
    foreach (held_usage[i]) held_usage[i] = 8'h00;
    fail_count  = 0;
    events_sent = 0;
    gapless     = 1'b0;
    cycle_count = 0;
    ready_run   = 0;
    stall_run   = 0;
    for (int k = 0; k < 256; k++) begin
      x = decode_key(k[7:0]);
      if (x.ok) typable_keys.push_back(k[7:0]);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_modifier_keys();
    test_usage_slots();
    test_unknown_keys();
    test_random_typing();

    wait_for_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ hid_keyboard_report_builder.f @@
hdl/hkrb_pkg.sv
hdl/hkrb_if.sv
hdl/hkrb_xlat.sv
hdl/hkrb_keystate.sv
hdl/hid_keyboard_report_builder.sv
sim/hid_keyboard_report_builder_tb.sv
